// ----- src/pwmseg_pkg.sv -----
// ----------------------------------------------------------------------------
// pwmseg_pkg
// Shared constants, types and the seven-segment digit table for the
// pwm dimmed segment shift driver.
// ----------------------------------------------------------------------------
package pwmseg_pkg;

    localparam int PWM_PERIOD      = 100;
    localparam int NUM_DIGITS      = 4;
    localparam int LOADABLE_DIGITS = (NUM_DIGITS < 4) ? NUM_DIGITS : 4;
    localparam int FRAME_BITS      = NUM_DIGITS * 8;
    localparam int BIT_CNT_W       = $clog2(FRAME_BITS + 1);
    localparam int TICK_W          = $clog2(PWM_PERIOD);
    localparam int BRIGHT_W        = 7;
    localparam int CMP_W           = (TICK_W + 1 > BRIGHT_W) ? TICK_W + 1 : BRIGHT_W;

    localparam logic [7:0]          BLANK_BYTE  = 8'hFF;
    localparam logic [BRIGHT_W-1:0] BRIGHT_INIT = BRIGHT_W'(50);

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_RAW   = 2'd1,
        ACT_DIGIT = 2'd2
    } action_t;

    // frame start request from the pwm timer to the shifter
    typedef struct packed {
        logic start;
        logic blank;
    } frame_req_t;

    typedef logic [NUM_DIGITS-1:0][7:0] seg_array_t;

    // common anode: 0 = segment lit, bit7 = a ... bit1 = g, bit0 = dot
    function automatic logic [7:0] digit_to_seg(input logic [7:0] v);
        logic [7:0] seg;
        case (v)
            8'd0:    seg = 8'b00000011;
            8'd1:    seg = 8'b10011111;
            8'd2:    seg = 8'b00100101;
            8'd3:    seg = 8'b00001101;
            8'd4:    seg = 8'b10011001;
            8'd5:    seg = 8'b01001001;
            8'd6:    seg = 8'b01000001;
            8'd7:    seg = 8'b00011111;
            8'd8:    seg = 8'b00000001;
            8'd9:    seg = 8'b00001001;
            default: seg = BLANK_BYTE;
        endcase
        return seg;
    endfunction

endpackage

// ----- src/pwm_dimmed_segment_shift_driver.sv -----
// ----------------------------------------------------------------------------
// pwm_dimmed_segment_shift_driver
// Seven-segment driver for a chain of serial shift registers, pwm dimmed.
// ----------------------------------------------------------------------------
// Input stream: s_tuser carries the action (tick, raw load, digit load),
// s_tdata the four digit values. Loads update the segment store in the
// cycle of the transfer and produce no output. A tick advances the pwm
// counter; on wrap the stored frame (or a blank frame at brightness 0) is
// shifted out, and when the counter equals the brightness a blank frame is.
// Output stream: one serial bit per transfer in m_tdata bit 0, highest digit
// first, each byte msb first; m_tlast marks the final bit, after which the
// latch is pulsed. A frame is 32 transfers, the first one valid the cycle
// after the tick. s_tready is low while a frame is shifting, so an item that
// starts a frame holds off the next item until the frame's final bit is
// taken. A receiver stall simply holds the current bit. Reset blanks all
// digits, clears the pwm counter and sets the brightness to 50. brightness_wr_en
// writes the brightness register.
// ----------------------------------------------------------------------------
module pwm_dimmed_segment_shift_driver (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            brightness_wr_en,
    input  logic [pwmseg_pkg::BRIGHT_W-1:0] brightness_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // value_0, value_1, value_2, value_3
    input  logic [1:0]                      s_tuser,   // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // serial_bit, zero fill
    output logic                            m_tlast    // latch_after
);

    logic [pwmseg_pkg::BRIGHT_W-1:0] bright_reg;
    logic [pwmseg_pkg::TICK_W-1:0]   tick_reg;
    logic [pwmseg_pkg::TICK_W-1:0]   tick_next;
    logic [pwmseg_pkg::CMP_W-1:0]    tick_inc;
    logic                            accept;
    logic                            busy;
    logic                            serial_bit;
    pwmseg_pkg::action_t             action;
    pwmseg_pkg::frame_req_t          req;
    pwmseg_pkg::seg_array_t          segments;

    assign action   = pwmseg_pkg::action_t'(s_tuser);
    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;
    assign tick_inc = pwmseg_pkg::CMP_W'(tick_reg) + 1'b1;

    always_comb
    begin
        tick_next = tick_reg;
        req       = '0;
        if (accept && action == pwmseg_pkg::ACT_TICK)
        begin
            if (tick_inc >= pwmseg_pkg::CMP_W'(pwmseg_pkg::PWM_PERIOD))
            begin
                tick_next = '0;
                req.start = 1'b1;
                req.blank = (bright_reg == '0);
            end
            else
            begin
                tick_next = tick_inc[pwmseg_pkg::TICK_W-1:0];
                // counter reaching the brightness blanks the display
                if (tick_inc == pwmseg_pkg::CMP_W'(bright_reg))
                begin
                    req.start = 1'b1;
                    req.blank = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg   <= '0;
            bright_reg <= pwmseg_pkg::BRIGHT_INIT;
        end
        else
        begin
            tick_reg <= tick_next;
            if (brightness_wr_en)
            begin
                bright_reg <= brightness_wr_data;
            end
        end
    end

    pwmseg_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .action   (action),
        .values   (s_tdata),
        .segments (segments)
    );

    pwmseg_shifter u_shifter (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .segments  (segments),
        .busy      (busy),
        .bit_valid (m_tvalid),
        .bit_ready (m_tready),
        .bit_data  (serial_bit),
        .bit_last  (m_tlast)
    );

    assign m_tdata = {7'b0, serial_bit};

endmodule

// ----- src/pwmseg_store.sv -----
// ----------------------------------------------------------------------------
// pwmseg_store
// Holds the segment bytes, loaded raw or through the digit table.
// ----------------------------------------------------------------------------
module pwmseg_store (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  pwmseg_pkg::action_t    action,
    input  logic [31:0]            values,
    output pwmseg_pkg::seg_array_t segments
);

    pwmseg_pkg::seg_array_t seg_reg;
    pwmseg_pkg::seg_array_t seg_next;

    always_comb
    begin
        seg_next = seg_reg;
        if (load)
        begin
            for (int i = 0; i < pwmseg_pkg::LOADABLE_DIGITS; i++)
            begin
                case (action)
                    pwmseg_pkg::ACT_RAW:   seg_next[i] = values[i*8 +: 8];
                    pwmseg_pkg::ACT_DIGIT: seg_next[i] =
                        pwmseg_pkg::digit_to_seg(values[i*8 +: 8]);
                    default:               seg_next[i] = seg_reg[i];
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= {pwmseg_pkg::NUM_DIGITS{pwmseg_pkg::BLANK_BYTE}};
        end
        else
        begin
            seg_reg <= seg_next;
        end
    end

    assign segments = seg_reg;

endmodule

// ----- src/pwmseg_shifter.sv -----
// ----------------------------------------------------------------------------
// pwmseg_shifter
// Frame shift register: one serial bit per output transfer, msb first.
// ----------------------------------------------------------------------------
module pwmseg_shifter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pwmseg_pkg::frame_req_t req,
    input  pwmseg_pkg::seg_array_t segments,
    output logic                   busy,
    output logic                   bit_valid,
    input  logic                   bit_ready,
    output logic                   bit_data,
    output logic                   bit_last
);

    logic [pwmseg_pkg::FRAME_BITS-1:0] shift_reg;
    logic [pwmseg_pkg::FRAME_BITS-1:0] shift_next;
    logic [pwmseg_pkg::BIT_CNT_W-1:0]  count_reg;
    logic [pwmseg_pkg::BIT_CNT_W-1:0]  count_next;
    logic                              take;

    assign take = bit_valid && bit_ready;

    always_comb
    begin
        shift_next = shift_reg;
        count_next = count_reg;
        if (req.start)
        begin
            if (req.blank)
            begin
                shift_next = '1;
            end
            else
            begin
                shift_next = segments;
            end
            count_next = pwmseg_pkg::BIT_CNT_W'(pwmseg_pkg::FRAME_BITS);
        end
        else if (take)
        begin
            shift_next = {shift_reg[pwmseg_pkg::FRAME_BITS-2:0], 1'b1};
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign busy      = (count_reg != '0);
    assign bit_valid = busy;
    assign bit_data  = shift_reg[pwmseg_pkg::FRAME_BITS-1];
    assign bit_last  = (count_reg == pwmseg_pkg::BIT_CNT_W'(1));

endmodule
